// File: hw/rtl/multi_task_liveness_watchdog_unit_defines.svh
// Assertion macros for the liveness watchdog.
// Used by the top level; depends on nothing.
`ifndef MULTI_TASK_LIVENESS_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_TASK_LIVENESS_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MTLW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchdog assertion failed");

// Next-cycle implication, disabled during reset
`define MTLW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchdog assertion failed");

`endif

// File: hw/rtl/mtlw_pkg.sv
// Shared types and constants of the liveness watchdog.
// No dependencies.
package mtlw_pkg;

    // Event kinds
    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_ALIVE    = 2'd1,
        OP_CHECK    = 2'd2,
        OP_TIMER    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } t_status;

    // Trip causes
    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_CLIENT  = 2'd1,
        CAUSE_CHECKER = 2'd2
    } t_cause;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    localparam logic [31:0] STALL_LIMIT_RESET = 32'd5000;

endpackage

// File: hw/rtl/mtlw_if.sv
// Valid/ready channel interfaces for the watchdog event and result words.
// No dependencies.
interface mtlw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] client_id;
    logic [31:0] time_ms;

    modport source (output valid, output op, output client_id, output time_ms, input ready);
    modport sink   (input valid, input op, input client_id, input time_ms, output ready);
endinterface

interface mtlw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        reset_request;
    logic [1:0]  reset_cause;
    logic [3:0]  stalled_slot;
    logic [4:0]  client_total;

    modport source (output valid, output status, output reset_request, output reset_cause,
                    output stalled_slot, output client_total, input ready);
    modport sink   (input valid, input status, input reset_request, input reset_cause,
                    input stalled_slot, input client_total, output ready);
endinterface

// File: hw/rtl/mtlw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtlw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/multi_task_liveness_watchdog_unit.sv
// Top level of the multi-client liveness watchdog.
// Depends on mtlw_pkg, mtlw_if, mtlw_ram and the assertion macro header.
//
// Usage:
//   i_in  : event words (op, client_id, time_ms), accepted when valid && ready.
//   o_out : one result word per event (status, reset_request, reset_cause,
//           stalled_slot, client_total), taken when valid && ready.
//   i_cfg_wr_en / i_cfg_wr_data write stall_limit_ms (reset value 5000).
// Flow:
//   register, timer and any event after a trip go from accept to ST_FIN and
//   then into the result register. alive and check: the scan reads one table
//   entry per cycle from the id and counter RAMs, over up to N registered
//   clients (stops early at a match or a stalled client).
//   One event is in work at a time; ready is high whenever the sequencer is
//   idle, also while an earlier result still waits in the output register.
// Reset: i_rst_n is synchronous, active low; table empty, no trip, all
//   snapshots read as zero (per-entry valid flags), limit back to 5000.
// Stall: if the receiver holds ready low, a finished result waits in the
//   sequencer until the output register frees, and no new event is taken.
`include "multi_task_liveness_watchdog_unit_defines.svh"

module multi_task_liveness_watchdog_unit #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtlw_in_if.sink     i_in,
    mtlw_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);
    import mtlw_pkg::*;

    localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);

    // sequencer state
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [31:0]         r_id, n_id;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    t_status             r_status, n_status;
    logic [CW-1:0]       r_total, n_total;
    logic [31:0]         r_last_chk, n_last_chk;
    t_cause              r_trip, n_trip;
    logic [IW-1:0]       r_slot, n_slot;
    logic [MAX_CLIENTS-1:0] r_snap_vld, n_snap_vld;
    logic [31:0]         r_stall_limit;

    // output register
    logic                r_out_vld;
    logic [1:0]          r_out_status;
    logic                r_out_req;
    logic [1:0]          r_out_cause;
    logic [3:0]          r_out_slot;
    logic [4:0]          r_out_total;

    // RAM ports
    logic                ids_we;
    logic [IW-1:0]       wr_addr;
    logic [31:0]         ids_q;
    logic                cnt_we;
    logic [63:0]         cnt_wdata;
    logic [63:0]         cnt_q;
    logic [IW-1:0]       rd_addr;

    logic                accept;
    logic                out_load;
    logic [31:0]         gap;
    logic [31:0]         kick_q;
    logic [31:0]         snap_q;
    logic [CW-1:0]       rd_next;
    logic                rd_last;
    logic [63:0]         slot_ext;
    logic [63:0]         total_ext;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign out_load = (r_state == ST_FIN) && (!r_out_vld || o_out.ready);
    assign gap      = i_in.time_ms - r_last_chk;
    assign kick_q   = cnt_q[63:32];
    assign snap_q   = r_snap_vld[r_rd_idx] ? cnt_q[31:0] : 32'd0;
    assign rd_next  = CW'(r_rd_idx) + CW'(1);
    assign rd_last  = (rd_next == r_total);

    // client id table
    mtlw_ram #(.WIDTH(32), .DEPTH(MAX_CLIENTS)) u_ids_ram (
        .i_clk   (i_clk),
        .i_we    (ids_we),
        .i_waddr (wr_addr),
        .i_wdata (i_in.client_id),
        .i_raddr (rd_addr),
        .o_rdata (ids_q)
    );

    // {kick count, snapshot} table
    mtlw_ram #(.WIDTH(64), .DEPTH(MAX_CLIENTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (wr_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cnt_q)
    );

    // next state and table access
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_idx[IW-1:0];
        n_status   = r_status;
        n_total    = r_total;
        n_last_chk = r_last_chk;
        n_trip     = r_trip;
        n_slot     = r_slot;
        n_snap_vld = r_snap_vld;
        ids_we     = 1'b0;
        cnt_we     = 1'b0;
        wr_addr    = r_rd_idx;
        cnt_wdata  = 64'd0;
        rd_addr    = r_idx[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_in.op);
                    n_id     = i_in.client_id;
                    n_idx    = '0;
                    n_status = STATUS_OK;
                    n_state  = ST_FIN;
                    if (r_trip == CAUSE_NONE) begin
                        case (t_op'(i_in.op))
                            OP_REGISTER: begin
                                if (r_total < CW'(MAX_CLIENTS)) begin
                                    ids_we    = 1'b1;
                                    cnt_we    = 1'b1;
                                    wr_addr   = r_total[IW-1:0];
                                    cnt_wdata = 64'd0;
                                    n_total   = r_total + CW'(1);
                                end else begin
                                    n_status = STATUS_FULL;
                                end
                            end
                            OP_ALIVE: begin
                                if (r_total == '0) begin
                                    n_status = STATUS_NOT_FOUND;
                                end else begin
                                    n_state = ST_SCAN;
                                end
                            end
                            OP_CHECK: begin
                                n_last_chk = i_in.time_ms;
                                if (r_total != '0) begin
                                    n_state = ST_SCAN;
                                end
                            end
                            OP_TIMER: begin
                                if (gap > r_stall_limit) begin
                                    n_trip = CAUSE_CHECKER;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            ST_SCAN: begin
                // issue the next table read
                if (r_idx < r_total) begin
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + CW'(1);
                end
                // evaluate the entry read last cycle
                if (r_rd_vld) begin
                    if (r_op == OP_ALIVE) begin
                        if (ids_q == r_id) begin
                            cnt_we    = 1'b1;
                            cnt_wdata = {kick_q + 32'd1, cnt_q[31:0]};
                            n_status  = STATUS_OK;
                            n_state   = ST_FIN;
                            n_rd_vld  = 1'b0;
                        end else if (rd_last) begin
                            n_status = STATUS_NOT_FOUND;
                            n_state  = ST_FIN;
                            n_rd_vld = 1'b0;
                        end
                    end else begin
                        if (snap_q == kick_q) begin
                            n_trip   = CAUSE_CLIENT;
                            n_slot   = r_rd_idx;
                            n_state  = ST_FIN;
                            n_rd_vld = 1'b0;
                        end else begin
                            cnt_we               = 1'b1;
                            cnt_wdata            = {kick_q, kick_q};
                            n_snap_vld[r_rd_idx] = 1'b1;
                            if (rd_last) begin
                                n_state  = ST_FIN;
                                n_rd_vld = 1'b0;
                            end
                        end
                    end
                end
            end

            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_vld   <= 1'b0;
            r_total    <= '0;
            r_last_chk <= 32'd0;
            r_trip     <= CAUSE_NONE;
            r_slot     <= '0;
            r_snap_vld <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_total    <= n_total;
            r_last_chk <= n_last_chk;
            r_trip     <= n_trip;
            r_slot     <= n_slot;
            r_snap_vld <= n_snap_vld;
        end
    end

    // per-event payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_status <= n_status;
    end

    // stall limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_limit <= STALL_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_stall_limit <= i_cfg_wr_data;
        end
    end

    // result word register
    assign slot_ext  = 64'(r_slot);
    assign total_ext = 64'(r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_req    <= (r_trip != CAUSE_NONE);
            r_out_cause  <= r_trip;
            r_out_slot   <= (r_trip == CAUSE_CLIENT) ? slot_ext[3:0] : 4'd0;
            r_out_total  <= total_ext[4:0];
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out_status;
    assign o_out.reset_request = r_out_req;
    assign o_out.reset_cause   = r_out_cause;
    assign o_out.stalled_slot  = r_out_slot;
    assign o_out.client_total  = r_out_total;

    // a trip holds until block reset
    `MTLW_ASSERT_NXT(a_trip_sticky, i_clk, i_rst_n, r_trip != CAUSE_NONE, $stable(r_trip))
    // table count never passes its depth
    `MTLW_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= CW'(MAX_CLIENTS))
    // table count only grows by one at a time
    `MTLW_ASSERT_IMP(a_total_step, i_clk, i_rst_n, !$stable(r_total),
                     r_total == $past(r_total) + CW'(1))
    // read data is only pending during a scan
    `MTLW_ASSERT_IMP(a_rd_in_scan, i_clk, i_rst_n, r_rd_vld, r_state == ST_SCAN)

endmodule

// File: test/tb.sv
// Self-checking testbench for multi_task_liveness_watchdog_unit.
// Depends on mtlw_pkg, mtlw_if and the RTL; a built-in watchdog model predicts
// the result words the script leaves untyped; scripted rows open and close the run, random rounds lie between.
module tb;
    import mtlw_pkg::*;

    localparam int NCLI        = 16;
    localparam int RAND_CAP    = NCLI - 2;   // two slots kept for the duplicate-id ending
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 40;
    localparam int PHASE_WORDS = 330;

    // Script sections
    localparam int OPEN_FIRST   = 0;
    localparam int OPEN_LAST    = 18;
    localparam int CLOSE_FIRST  = 19;
    localparam int CLOSE_LAST   = 23;
    localparam int CLIENT_FIRST = 24;
    localparam int CHECKR_FIRST = 28;
    localparam int TRIP_ROWS    = 4;

    typedef struct packed {
        t_status    status;
        logic       req;
        t_cause     cause;
        logic [3:0] slot;
        logic [4:0] total;
    } t_result;

    typedef struct {
        t_op         op;
        logic [31:0] id;
        logic [31:0] tm;
        bit          typed;
        t_result     want;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    mtlw_in_if  ev_if ();
    mtlw_out_if res_if ();

    multi_task_liveness_watchdog_unit #(.MAX_CLIENTS(NCLI)) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (ev_if),
        .o_out         (res_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Clock, period 10
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog model state
    logic [31:0] wd_ids    [NCLI] = '{default: '0};
    logic [31:0] wd_kicks  [NCLI] = '{default: '0};
    logic [31:0] wd_snaps  [NCLI] = '{default: '0};
    bit          wd_active [NCLI] = '{default: 1'b0};
    logic [4:0]  wd_total      = '0;
    logic [31:0] wd_last_check = '0;
    t_cause      wd_trip       = CAUSE_NONE;
    logic [3:0]  wd_trip_slot  = '0;
    logic [31:0] wd_limit      = STALL_LIMIT_RESET;

    t_result due_results [$];
    int      n_fail    = 0;
    int      n_results = 0;
    int      n_sent    = 0;
    int      cycles    = 0;
    bit      burst     = 1'b0;
    bit      hold_go   = 1'b0;
    bit      hold      = 1'b0;
    bit      rdy_on    = 1'b0;
    int      rdy_left  = 0;

    // Directed script; typed results only where they are obvious
    t_row script [0:31] = '{
        // empty table: timer, check at max time, alive not found
        '{OP_TIMER,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd0}},
        '{OP_CHECK,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd0}},
        // gap of exactly 5000 across the time wrap: no trip
        '{OP_TIMER,    32'hFFFF_FFFF, 32'h0000_1387, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd0}},
        '{OP_ALIVE,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STATUS_NOT_FOUND, 1'b0, CAUSE_NONE, 4'd0, 5'd0}},
        '{OP_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd1}},
        '{OP_REGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd2}},
        '{OP_ALIVE,    32'h0000_0000, 32'h8000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd2}},
        '{OP_ALIVE,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd2}},
        '{OP_ALIVE,    32'h8000_0000, 32'h0000_0000, 1'b1,
          '{STATUS_NOT_FOUND, 1'b0, CAUSE_NONE, 4'd0, 5'd2}},
        '{OP_CHECK,    32'h0000_0000, 32'h0000_1000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd2}},
        '{OP_REGISTER, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd3}},
        '{OP_REGISTER, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd4}},
        '{OP_ALIVE,    32'h5555_5555, 32'h0000_0000, 1'b0, '0},
        '{OP_ALIVE,    32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
        '{OP_ALIVE,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{OP_ALIVE,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{OP_ALIVE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_TIMER,    32'h0000_0000, 32'h0000_2388, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd4}},
        '{OP_CHECK,    32'hFFFF_FFFF, 32'h0000_2388, 1'b0, '0},
        // closing: 14 entries all kicked; duplicates fill the table
        '{OP_REGISTER, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd15}},
        '{OP_REGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd16}},
        '{OP_REGISTER, 32'h0000_0005, 32'h0000_0000, 1'b1,
          '{STATUS_FULL, 1'b0, CAUSE_NONE, 4'd0, 5'd16}},
        '{OP_ALIVE,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd16}},
        '{OP_ALIVE,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b0, CAUSE_NONE, 4'd0, 5'd16}},
        // client stall: duplicate at slot 14 never gets a kick
        '{OP_CHECK,    32'h0000_0000, 32'h7000_0010, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CLIENT, 4'd14, 5'd16}},
        '{OP_TIMER,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CLIENT, 4'd14, 5'd16}},
        '{OP_REGISTER, 32'h0000_0007, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CLIENT, 4'd14, 5'd16}},
        '{OP_ALIVE,    32'h1234_5678, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CLIENT, 4'd14, 5'd16}},
        // checker stall: limit is 1, last check at 0x7000_0000
        '{OP_TIMER,    32'h0000_0000, 32'h7000_0002, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CHECKER, 4'd0, 5'd16}},
        '{OP_CHECK,    32'h0000_0000, 32'h7000_0002, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CHECKER, 4'd0, 5'd16}},
        '{OP_REGISTER, 32'h0000_0007, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CHECKER, 4'd0, 5'd16}},
        '{OP_ALIVE,    32'h1234_5678, 32'h0000_0000, 1'b1,
          '{STATUS_OK, 1'b1, CAUSE_CHECKER, 4'd0, 5'd16}}
    };

    // Advance the watchdog model by one event word
    function automatic t_result watchdog_step(t_op op, logic [31:0] id, logic [31:0] tm);
        t_result     r;
        logic [31:0] gap;
        bit          done;
        r      = '0;
        done   = 1'b0;
        if (wd_trip == CAUSE_NONE) begin
            case (op)
                OP_REGISTER: begin
                    if (wd_total >= NCLI) begin
                        r.status = STATUS_FULL;
                    end else begin
                        wd_ids[wd_total]    = id;
                        wd_kicks[wd_total]  = '0;
                        wd_active[wd_total] = 1'b1;
                        wd_total            = wd_total + 1'b1;
                    end
                end
                OP_ALIVE: begin
                    r.status = STATUS_NOT_FOUND;
                    for (int i = 0; i < wd_total; i++) begin
                        if (!done && wd_ids[i] == id) begin
                            wd_kicks[i] = wd_kicks[i] + 1;
                            r.status    = STATUS_OK;
                            done        = 1'b1;
                        end
                    end
                end
                OP_CHECK: begin
                    wd_last_check = tm;
                    for (int i = 0; i < wd_total; i++) begin
                        if (!done && wd_active[i]) begin
                            if (wd_snaps[i] == wd_kicks[i]) begin
                                wd_trip      = CAUSE_CLIENT;
                                wd_trip_slot = i[3:0];
                                done         = 1'b1;
                            end else begin
                                wd_snaps[i] = wd_kicks[i];
                            end
                        end
                    end
                end
                default: begin
                    gap = tm - wd_last_check;
                    if (gap > wd_limit) wd_trip = CAUSE_CHECKER;
                end
            endcase
        end
        r.req   = (wd_trip != CAUSE_NONE);
        r.cause = wd_trip;
        r.slot  = (wd_trip == CAUSE_CLIENT) ? wd_trip_slot : 4'd0;
        r.total = wd_total;
        return r;
    endfunction

    function automatic string fmt_result(t_result r);
        return $sformatf("status=%0d req=%0d cause=%0d slot=%0d total=%0d",
                         r.status, r.req, r.cause, r.slot, r.total);
    endfunction

    function automatic void note_failure(string msg);
        n_fail++;
        if (n_fail <= 10) $display("ERROR: %s", msg);
    endfunction

    // Random id not present in the table
    function automatic logic [31:0] unused_id();
        logic [31:0] v;
        bit          clash;
        do begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom;
            clash = 1'b0;
            for (int i = 0; i < wd_total; i++)
                if (wd_ids[i] == v) clash = 1'b1;
        end while (clash);
        return v;
    endfunction

    // Timer time within the stall limit, sometimes right on it
    function automatic logic [31:0] timer_time();
        logic [31:0] span;
        if ($urandom_range(0, 3) == 0)
            span = wd_limit;
        else if (wd_limit == 32'hFFFF_FFFF)
            span = $urandom;
        else
            span = $urandom_range(0, wd_limit);
        return wd_last_check + span;
    endfunction

    // Offer one event word, hold it until taken, then queue its result
    task automatic send_word(t_op op, logic [31:0] id, logic [31:0] tm,
                             bit typed, t_result want);
        int      gap;
        int      sel;
        t_result r;
        gap = 0;
        if (!burst) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)      gap = 0;
            else if (sel < 85) gap = $urandom_range(1, 3);
            else if (sel < 96) gap = $urandom_range(4, 12);
            else               gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_if.valid     <= 1'b1;
        ev_if.op        <= op;
        ev_if.client_id <= id;
        ev_if.time_ms   <= tm;
        do @(posedge clk); while (!ev_if.ready);
        r = watchdog_step(op, id, tm);
        due_results.push_back(typed ? want : r);
        n_sent++;
    endtask

    task automatic play_rows(int first, int last);
        for (int r = first; r <= last; r++)
            send_word(script[r].op, script[r].id, script[r].tm, script[r].typed,
                      script[r].want);
    endtask

    // Limit is written only with no event in flight
    task automatic write_limit(logic [31:0] v);
        ev_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        wd_limit = v;
    endtask

    // One well-formed period: maybe register, kick every entry, then check
    task automatic run_round();
        logic [31:0] kicks [$];
        logic [31:0] tmp;
        int          n;
        int          j;
        int          sel;
        burst = ($urandom_range(0, 4) == 0);
        if (wd_total < RAND_CAP && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n && wd_total < RAND_CAP; i++)
                send_word(OP_REGISTER, unused_id(), $urandom, 1'b0, '0);
        end
        for (int i = 0; i < wd_total; i++) begin
            n = $urandom_range(1, 3);
            repeat (n) kicks.push_back(wd_ids[i]);
        end
        for (int i = kicks.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = kicks[i];
            kicks[i] = kicks[j];
            kicks[j] = tmp;
        end
        for (int i = 0; i < kicks.size(); i++) begin
            // noise between kicks: unknown ids and timers inside the limit
            if ($urandom_range(0, 5) == 0) begin
                sel = $urandom_range(0, 1);
                if (sel == 0)
                    send_word(OP_ALIVE, unused_id(), $urandom, 1'b0, '0);
                else
                    send_word(OP_TIMER, $urandom, timer_time(), 1'b0, '0);
            end
            send_word(OP_ALIVE, kicks[i], $urandom, 1'b0, '0);
        end
        if ($urandom_range(0, 1) == 0)
            send_word(OP_TIMER, $urandom, timer_time(), 1'b0, '0);
        send_word(OP_CHECK, $urandom,
                  ($urandom_range(0, 1) == 0) ? $urandom
                                              : wd_last_check + $urandom_range(0, 1000),
                  1'b0, '0);
    endtask

    // Stimulus
    initial begin : stimulus
        logic [31:0] lim;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        ev_if.valid     <= 1'b0;
        ev_if.op        <= OP_REGISTER;
        ev_if.client_id <= '0;
        ev_if.time_ms   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        play_rows(OPEN_FIRST, OPEN_LAST);

        // random phases, each under its own stall limit
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       lim = 32'hFFFF_FFFF;
                1:       lim = $urandom_range(200, 100000);
                2:       lim = STALL_LIMIT_RESET;
                3:       lim = $urandom_range(1, 20);
                default: lim = 32'd1;
            endcase
            write_limit(lim);
            if (ph == 1) hold_go = 1'b1;
            while (n_sent < OPEN_LAST + 1 + PHASE_WORDS * (ph + 1))
                run_round();
        end

        // closing: 14 entries, all kicked, check at a known time, kick again
        burst = 1'b0;
        while (wd_total < RAND_CAP)
            send_word(OP_REGISTER, unused_id(), $urandom, 1'b0, '0);
        for (int i = 0; i < wd_total; i++)
            send_word(OP_ALIVE, wd_ids[i], $urandom, 1'b0, '0);
        send_word(OP_CHECK, $urandom, 32'h7000_0000, 1'b0, '0);
        for (int i = 0; i < wd_total; i++)
            send_word(OP_ALIVE, wd_ids[i], $urandom, 1'b0, '0);
        play_rows(CLOSE_FIRST, CLOSE_LAST);
        if ($urandom_range(0, 1) == 0)
            play_rows(CLIENT_FIRST, CLIENT_FIRST + TRIP_ROWS - 1);
        else
            play_rows(CHECKR_FIRST, CHECKR_FIRST + TRIP_ROWS - 1);
        ev_if.valid <= 1'b0;

        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin : hold_off
        wait (hold_go);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // Result side: check taken words, then pick the next ready pattern
    always @(posedge clk) begin : result_side
        t_result got;
        t_result want;
        int      sel;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.status = t_status'(res_if.status);
            got.req    = res_if.reset_request;
            got.cause  = t_cause'(res_if.reset_cause);
            got.slot   = res_if.stalled_slot;
            got.total  = res_if.client_total;
            if (due_results.size() == 0) begin
                note_failure($sformatf("result %0d with nothing pending: %s",
                                       n_results, fmt_result(got)));
            end else begin
                want = due_results.pop_front();
                if (got !== want)
                    note_failure($sformatf("result %0d expected %s, actual %s",
                                           n_results, fmt_result(want), fmt_result(got)));
            end
            n_results++;
        end
        if (rdy_left == 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                rdy_on   = 1'b1;
                rdy_left = $urandom_range(1, 8);
            end else if (sel < 50) begin
                rdy_on   = 1'b1;
                rdy_left = $urandom_range(50, 200);
            end else if (sel < 85) begin
                rdy_on   = 1'b0;
                rdy_left = $urandom_range(1, 3);
            end else if (sel < 96) begin
                rdy_on   = 1'b0;
                rdy_left = $urandom_range(4, 12);
            end else begin
                rdy_on   = 1'b0;
                rdy_left = $urandom_range(20, 60);
            end
        end else begin
            rdy_left--;
        end
        res_if.ready <= rdy_on && !hold;
    end

    // Run-away guard
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mtlw_pkg.sv
hw/rtl/mtlw_if.sv
hw/rtl/mtlw_ram.sv
hw/rtl/multi_task_liveness_watchdog_unit.sv
test/tb.sv
